FILE: rtl/pse_pkg.sv
package pse_pkg;

  localparam int VALUE_W = 32;
  localparam int FLIP_W  = 7;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_FLIP_RD,
    ST_FLIP_WLO,
    ST_FLIP_WHI,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

endpackage

FILE: rtl/pancake_sort_engine_top.sv
// load: item_ready is high in ST_LOAD; after the final value the sort runs, then each result
//   is read and held on the output until it transfers; sort: per prefix p a pipelined max scan
//   and a decide step, and per reversal a read and then paired writes on the single write port
// sets: one set at a time, no new value is taken until the last result of a set transfers
// reset: rst (synchronous) clears the value and flip counts, flags and state; the value store is not cleared
module pancake_sort_engine_top import pse_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic                      is_final,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic signed [VALUE_W-1:0] sorted_value,
  output logic                      end_of_set,
  output logic [FLIP_W-1:0]         flip_total,
  output logic                      overflowed
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_a, rd_b;
  logic               rd_en;
  logic [AW-1:0]      addr_a, addr_b;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;

  logic [CW-1:0]      count;
  logic [FLIP_W-1:0]  flips;
  logic               dropped;
  logic [CW-1:0]      plen;
  logic [CW-1:0]      scan_idx;
  logic               cmp_valid;
  logic [AW-1:0]      cmp_idx;
  logic [VALUE_W-1:0] best;
  logic [AW-1:0]      best_idx;
  logic [AW-1:0]      lo, hi;
  logic               second_flip;
  logic [AW-1:0]      emit_idx;

  logic               in_xfer, out_xfer;
  logic               has_room;
  logic [CW-1:0]      count_after;
  logic [CW-1:0]      plen_m1;
  logic [AW-1:0]      last_idx;
  logic               scan_issue, scan_done;
  logic               more_pairs;

  assign in_xfer     = item_valid && item_ready;
  assign out_xfer    = result_valid && result_ready;
  assign has_room    = count < CW'(CAPACITY);
  assign count_after = has_room ? count + 1'b1 : count;
  assign plen_m1     = plen - 1'b1;
  assign last_idx    = AW'(count - 1'b1);
  assign scan_issue  = scan_idx < plen;
  assign scan_done   = cmp_valid && (cmp_idx == AW'(plen_m1));
  assign more_pairs  = ({1'b0, lo} + (AW+1)'(2)) < {1'b0, hi};

  // store: two registered read ports, one write port; flips never read an entry being written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_xfer && is_final) begin
          state_next = (count_after > CW'(1)) ? ST_SCAN : ST_EMIT_RD;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (best_idx != AW'(plen_m1)) begin
          state_next = ST_FLIP_RD;
        end else if (plen_m1 > CW'(1)) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_FLIP_RD:  state_next = ST_FLIP_WLO;
      ST_FLIP_WLO: state_next = ST_FLIP_WHI;
      ST_FLIP_WHI: begin
        if (more_pairs) begin
          state_next = ST_FLIP_WLO;
        end else if (second_flip) begin
          state_next = ST_FLIP_RD;
        end else if (plen_m1 > CW'(1)) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_xfer) begin
          state_next = end_of_set ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    item_ready   = 1'b0;
    result_valid = 1'b0;
    rd_en        = 1'b0;
    addr_a       = lo;
    addr_b       = hi;
    we           = 1'b0;
    waddr        = lo;
    wdata        = rd_b;
    unique case (state)
      ST_LOAD: begin
        item_ready = 1'b1;
        we         = in_xfer && has_room;
        waddr      = AW'(count);
        wdata      = item_value;
      end
      ST_SCAN: begin
        rd_en  = scan_issue;
        addr_a = AW'(scan_idx);
      end
      ST_FLIP_RD: begin
        rd_en = 1'b1;
      end
      ST_FLIP_WLO: begin
        we    = 1'b1;
        waddr = lo;
        wdata = rd_b;
      end
      ST_FLIP_WHI: begin
        we     = 1'b1;
        waddr  = hi;
        wdata  = rd_a;
        // fetch the next pair while the high entry is written back
        rd_en  = more_pairs;
        addr_a = lo + 1'b1;
        addr_b = hi - 1'b1;
      end
      ST_EMIT_RD: begin
        rd_en  = 1'b1;
        addr_a = emit_idx;
      end
      ST_EMIT_OUT: begin
        result_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign sorted_value = rd_a;
  assign end_of_set   = emit_idx == last_idx;
  assign flip_total   = flips;
  assign overflowed   = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      count       <= '0;
      flips       <= '0;
      dropped     <= 1'b0;
      cmp_valid   <= 1'b0;
      second_flip <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == ST_SCAN) && scan_issue;
      unique case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            count <= count_after;
            if (!has_room) begin
              dropped <= 1'b1;
            end
            plen     <= count_after;
            scan_idx <= '0;
            emit_idx <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          cmp_idx <= AW'(scan_idx);
          if (cmp_valid && (cmp_idx == '0 || $signed(rd_a) > $signed(best))) begin
            best     <= rd_a;
            best_idx <= cmp_idx;
          end
        end
        ST_DECIDE: begin
          lo       <= '0;
          scan_idx <= '0;
          emit_idx <= '0;
          if (best_idx == AW'(plen_m1)) begin
            plen <= plen_m1;
          end else if (best_idx != '0) begin
            hi          <= best_idx;
            second_flip <= 1'b1;
            flips       <= flips + 1'b1;
          end else begin
            hi          <= AW'(plen_m1);
            second_flip <= 1'b0;
            flips       <= flips + 1'b1;
          end
        end
        ST_FLIP_WHI: begin
          scan_idx <= '0;
          emit_idx <= '0;
          if (more_pairs) begin
            lo <= lo + 1'b1;
            hi <= hi - 1'b1;
          end else if (second_flip) begin
            lo          <= '0;
            hi          <= AW'(plen_m1);
            second_flip <= 1'b0;
            flips       <= flips + 1'b1;
          end else begin
            plen <= plen_m1;
          end
        end
        ST_EMIT_OUT: begin
          if (out_xfer) begin
            if (end_of_set) begin
              count   <= '0;
              flips   <= '0;
              dropped <= 1'b0;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/pse_checker.sv
module pse_checker import pse_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_ready,
  input logic                      is_final,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic signed [VALUE_W-1:0] sorted_value,
  input logic                      end_of_set,
  input logic [FLIP_W-1:0]         flip_total,
  input logic                      overflowed
);

  logic in_xfer, out_xfer;
  assign in_xfer  = item_valid && item_ready;
  assign out_xfer = result_valid && result_ready;

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(sorted_value))
    else $error("result changed while stalled");

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("input ready while a result is pending");

  // a value that does not close the set gives no result
  a_quiet_load: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !is_final |=> !result_valid && item_ready)
    else $error("result after a non-final value");

  // the last result of a set frees the input
  a_set_done: assert property (@(posedge clk) disable iff (rst)
    out_xfer && end_of_set |=> item_ready && !result_valid)
    else $error("input not ready after end of set");

  // flip count and overflow flag hold across the results of one set
  a_flip_steady: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !end_of_set |-> ##2 (result_valid && flip_total == $past(flip_total, 2)
      && overflowed == $past(overflowed, 2)))
    else $error("set summary changed within a set");

endmodule

bind pancake_sort_engine_top pse_checker u_pse_checker (.*);

FILE: bench/pancake_sort_checker.sv
`timescale 1ns / 100ps

module pancake_sort_checker import pse_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      item_ready,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic                      is_final,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic signed [VALUE_W-1:0] sorted_value,
  input  logic                      end_of_set,
  input  logic [FLIP_W-1:0]         flip_total,
  input  logic                      overflowed,
  output int                        error_count,
  output int                        pending_results
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      end_mark;
    logic [FLIP_W-1:0]         flips;
    logic                      dropped;
  } sorted_entry_t;

  sorted_entry_t             sorted_q[$];
  logic signed [VALUE_W-1:0] stack_vals[CAPACITY];
  int                        stack_len;
  bit                        drop_seen;

  function automatic void flip_front(int upto);
    int lo;
    int hi;
    logic signed [VALUE_W-1:0] tmp;
    lo = 0;
    hi = upto;
    while (lo < hi) begin
      tmp = stack_vals[lo];
      stack_vals[lo] = stack_vals[hi];
      stack_vals[hi] = tmp;
      lo++;
      hi--;
    end
  endfunction

  // first index of the strict maximum within the prefix
  function automatic int find_peak(int len);
    int best;
    best = 0;
    for (int j = 1; j < len; j++)
      if (stack_vals[j] > stack_vals[best]) best = j;
    return best;
  endfunction

  function automatic int pancake_sort();
    int flips;
    int peak;
    flips = 0;
    for (int p = stack_len; p > 1; p--) begin
      peak = find_peak(p);
      if (peak != p - 1) begin
        if (peak != 0) begin
          flip_front(peak);
          flips++;
        end
        flip_front(p - 1);
        flips++;
      end
    end
    return flips;
  endfunction

  function automatic void take_item(logic signed [VALUE_W-1:0] v, logic fin);
    int flips;
    sorted_entry_t entry;
    if (stack_len < CAPACITY) begin
      stack_vals[stack_len] = v;
      stack_len++;
    end else begin
      drop_seen = 1'b1;
    end
    if (fin) begin
      flips = pancake_sort();
      for (int k = 0; k < stack_len; k++) begin
        entry.value    = stack_vals[k];
        entry.end_mark = (k == stack_len - 1);
        entry.flips    = flips[FLIP_W-1:0];
        entry.dropped  = drop_seen;
        sorted_q.push_back(entry);
      end
      stack_len = 0;
      drop_seen = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(string what, logic signed [VALUE_W-1:0] exp_val,
                                        logic signed [VALUE_W-1:0] act_val);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_val, act_val);
  endfunction

  always @(posedge clk) begin
    sorted_entry_t want;
    if (rst) begin
      sorted_q.delete();
      stack_len = 0;
      drop_seen = 1'b0;
      error_count = 0;
    end else begin
      // results leave before a new set can be closed, so check them first
      if (result_valid && result_ready) begin
        if (sorted_q.size() == 0) begin
          note_mismatch("unexpected result, value", 0, sorted_value);
        end else begin
          want = sorted_q.pop_front();
          if (sorted_value !== want.value)
            note_mismatch("sorted_value", want.value, sorted_value);
          if (end_of_set !== want.end_mark)
            note_mismatch("end_of_set", VALUE_W'(want.end_mark), VALUE_W'(end_of_set));
          if (flip_total !== want.flips)
            note_mismatch("flip_total", VALUE_W'(want.flips), VALUE_W'(flip_total));
          if (overflowed !== want.dropped)
            note_mismatch("overflowed", VALUE_W'(want.dropped), VALUE_W'(overflowed));
        end
      end
      if (item_valid && item_ready) take_item(item_value, is_final);
    end
    pending_results = sorted_q.size();
  end

endmodule

FILE: bench/tb_pancake_sort_engine_top.sv
`timescale 1ns / 100ps

module tb_pancake_sort_engine_top;
  import pse_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int ITEM_COUNT = 120;
  localparam int IDLE_LIMIT = 4000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid;
  logic                      item_ready;
  logic signed [VALUE_W-1:0] item_value;
  logic                      is_final;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic signed [VALUE_W-1:0] sorted_value;
  logic                      end_of_set;
  logic [FLIP_W-1:0]         flip_total;
  logic                      overflowed;

  int error_count;
  int pending_results;
  int idle_cycles = 0;
  int ready_hold  = 0;
  int calm_left   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pancake_sort_engine_top #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_value   (item_value),
    .is_final     (is_final),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sorted_value (sorted_value),
    .end_of_set   (end_of_set),
    .flip_total   (flip_total),
    .overflowed   (overflowed)
  );

  pancake_sort_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item_value      (item_value),
    .is_final        (is_final),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .sorted_value    (sorted_value),
    .end_of_set      (end_of_set),
    .flip_total      (flip_total),
    .overflowed      (overflowed),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  // mostly short gaps, a few long ones, and now and then a calm stretch with none
  function automatic int pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic signed [VALUE_W-1:0] v, logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_value <= v;
    is_final   <= fin;
    do @(posedge clk); while (!item_ready);
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      result_ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      result_ready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent;
    int set_len;
    item_valid <= 1'b0;
    item_value <= '0;
    is_final   <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single value, then pairs at the extremes in both orders
    send_item(32'sh7fffffff, 1'b1);
    send_item(32'sh80000000, 1'b0);
    send_item(32'sh7fffffff, 1'b1);
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b1);
    // equal maxima, the lower index must win
    send_item(-1, 1'b0);
    send_item(5, 1'b0);
    send_item(5, 1'b0);
    send_item(0, 1'b1);
    // full descending store, the final value is dropped
    for (int i = 0; i <= CAPACITY; i++) begin
      if (i == CAPACITY - 1)
        send_item(32'sh80000000, 1'b0);
      else
        send_item(32'sh7fffffff - i * 134217728, i == CAPACITY);
    end

    // the directed items above count toward the total
    sent = 10 + CAPACITY;
    while (sent < ITEM_COUNT) begin
      case ($urandom_range(0, 9))
        0:       set_len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
        1:       set_len = CAPACITY;
        2:       set_len = $urandom_range(1, 2);
        default: set_len = $urandom_range(1, 12);
      endcase
      for (int k = 0; k < set_len; k++)
        send_item(pick_value(), k == set_len - 1);
      sent += set_len;
    end
    item_valid <= 1'b0;

    // let the checker see the last transfer before polling its queue
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
rtl/pse_pkg.sv
rtl/pancake_sort_engine_top.sv
rtl/pse_checker.sv
bench/pancake_sort_checker.sv
bench/tb_pancake_sort_engine_top.sv
